@@ hw/rtl/cpss_pkg.sv @@
// shared types, constants and helpers of the convex polygon span scan core
package cpss_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MAX_ROWS   = 64;
  localparam int COORD_BITS = 16;

  localparam int PT_BITS    = $clog2(MAX_POINTS);
  localparam int VADDR_BITS = PT_BITS + 1;
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 2);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int DIVC_BITS  = $clog2(COORD_BITS + 1);
  localparam int DQ_DEPTH   = 2;
  localparam int DQ_PTR     = $clog2(DQ_DEPTH);
  localparam int DQ_CNT     = $clog2(DQ_DEPTH + 1);

  localparam logic [1:0] EDGE_L = 2'b01;
  localparam logic [1:0] EDGE_R = 2'b10;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TALL = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] row_y;
    logic signed [COORD_BITS-1:0] span_left;
    logic signed [COORD_BITS-1:0] span_right;
    logic                         last_row;
    logic [1:0]                   status;
  } out_item_t;

  // one finished polygon handed from front to back
  typedef struct packed {
    logic                         bank;
    logic [PT_BITS-1:0]           nlast;
    logic signed [COORD_BITS-1:0] ymin;
    logic [ROW_BITS-1:0]          hm1;
    logic [1:0]                   status;
  } desc_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_STAT,
    B_MRD,
    B_MROW,
    B_MWR,
    B_PREP,
    B_FRD,
    B_FCHK,
    B_DIV,
    B_FILL,
    B_ERD,
    B_EPUT,
    B_DONE
  } back_state_t;

  function automatic logic [1:0] side_prev(input logic signed [COORD_BITS-1:0] y,
                                           input logic signed [COORD_BITS-1:0] yp);
    logic [1:0] s;
    s = 2'b00;
    if (y < yp) s = EDGE_R;
    else if (y > yp) s = EDGE_L;
    return s;
  endfunction

  function automatic logic [1:0] side_next(input logic signed [COORD_BITS-1:0] y,
                                           input logic signed [COORD_BITS-1:0] yn);
    logic [1:0] s;
    s = 2'b00;
    if (yn < y) s = EDGE_R;
    else if (yn > y) s = EDGE_L;
    return s;
  endfunction

endpackage

@@ hw/rtl/convex_polygon_span_scan_core.sv @@
// top level of the convex polygon span scan core
// Vertices go in one per clock while a vertex bank is free; two banks let the next
// polygon load while the previous one is still scanned. After the last vertex the back
// end marks rows with a vertex read, row lookup and write per vertex (B_MRD, B_MROW,
// B_MWR), then makes the left and then the right edge fill pass, reading and checking
// each row and, at each edge gap, waiting on the restoring divide and then filling the
// gap rows, then reads and emits one span per row, stalling while the output is not
// drained; a rejected polygon (too many vertices or too tall) gives its single status
// span once the back end is free. The row stores are rams with a registered read, so
// each mark, check and emission step waits on the read; only the gap fill writes one row per cycle.
module convex_polygon_span_scan_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  cpss_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output cpss_pkg::out_item_t out_data
);
  import cpss_pkg::*;

  logic                      fifo_full, fifo_empty, desc_push, desc_pop;
  desc_t                     desc_in, desc_head;
  logic                      vram_we;
  logic [VADDR_BITS-1:0]     vram_waddr, vram_raddr, side_idx;
  logic [2*COORD_BITS-1:0]   vram_wdata, vram_rdata;
  logic [1:0]                side_data;

  cpss_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .fifo_full(fifo_full), .desc_push(desc_push), .desc_data(desc_in),
    .vram_we(vram_we), .vram_waddr(vram_waddr), .vram_wdata(vram_wdata),
    .side_idx(side_idx), .side_data(side_data)
  );

  cpss_ram #(.WIDTH(2*COORD_BITS), .DEPTH(2*MAX_POINTS)) u_vram (
    .clk(clk), .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
    .raddr(vram_raddr), .rdata_r(vram_rdata)
  );

  cpss_desc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(desc_push), .push_data(desc_in), .full(fifo_full),
    .pop(desc_pop), .empty(fifo_empty), .head(desc_head)
  );

  cpss_back u_back (
    .clk(clk), .rst_n(rst_n),
    .desc_empty(fifo_empty), .desc_head(desc_head), .desc_pop(desc_pop),
    .vram_raddr(vram_raddr), .vram_rdata(vram_rdata),
    .side_idx(side_idx), .side_data(side_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

endmodule

@@ hw/rtl/cpss_ram.sv @@
// generic simple dual-port ram with registered read
module cpss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

endmodule

@@ hw/rtl/cpss_div.sv @@
// restoring divider, one quotient bit per cycle
module cpss_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cpss_pkg::COORD_BITS-1:0] dividend,
  input  logic [cpss_pkg::ROW_BITS-1:0]   divisor,
  output logic                          done,
  output logic [cpss_pkg::COORD_BITS-1:0] quot,
  output logic [cpss_pkg::ROW_BITS-1:0]   rem
);
  import cpss_pkg::*;

  logic                  busy_r, done_r;
  logic [DIVC_BITS-1:0]  cnt_r;
  logic [COORD_BITS-1:0] q_r;
  logic [ROW_BITS-1:0]   rem_r, dvs_r;
  logic [ROW_BITS:0]     trial;
  logic                  ge;

  assign trial = {rem_r, q_r[COORD_BITS-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIVC_BITS'(COORD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIVC_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[COORD_BITS-2:0], ge};
      rem_r <= ge ? ROW_BITS'(trial - {1'b0, dvs_r}) : trial[ROW_BITS-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

@@ hw/rtl/cpss_front.sv @@
// front: takes vertices, classifies edges, tracks row range, emits polygon descriptors
module cpss_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  cpss_pkg::in_item_t              in_data,
  input  logic                            fifo_full,
  output logic                            desc_push,
  output cpss_pkg::desc_t                 desc_data,
  output logic                            vram_we,
  output logic [cpss_pkg::VADDR_BITS-1:0] vram_waddr,
  output logic [2*cpss_pkg::COORD_BITS-1:0] vram_wdata,
  input  logic [cpss_pkg::VADDR_BITS-1:0] side_idx,
  output logic [1:0]                      side_data
);
  import cpss_pkg::*;

  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic                         bank_r;
  logic signed [COORD_BITS-1:0] y0_r, yprev_r, ymin_r, ymax_r;
  logic [1:0]                   sp_r [2*MAX_POINTS];
  logic [1:0]                   sn_r [2*MAX_POINTS];

  logic                         accept, store, first, last;
  logic [PT_BITS-1:0]           idx, prev_idx;
  logic signed [COORD_BITS-1:0] px, py, y0e, mn, mx;
  logic [COORD_BITS:0]          span;
  logic                         tall;

  assign px       = in_data.point_x;
  assign py       = in_data.point_y;
  assign last     = in_data.last_point;
  assign in_full  = fifo_full;
  assign accept   = in_push && !fifo_full;
  assign store    = cnt_r < CNT_BITS'(MAX_POINTS);
  assign first    = cnt_r == '0;
  assign idx      = cnt_r[PT_BITS-1:0];
  assign prev_idx = idx - 1'b1;
  assign y0e      = first ? py : y0_r;
  assign mn       = first ? py : ((py < ymin_r) ? py : ymin_r);
  assign mx       = first ? py : ((py > ymax_r) ? py : ymax_r);
  assign span     = {mx[COORD_BITS-1], mx} - {mn[COORD_BITS-1], mn};
  assign tall     = span >= (COORD_BITS+1)'(MAX_ROWS);

  assign vram_we    = accept && store;
  assign vram_waddr = {bank_r, idx};
  assign vram_wdata = {px, py};

  assign desc_push        = accept && last;
  assign desc_data.bank   = bank_r;
  assign desc_data.nlast  = idx;
  assign desc_data.ymin   = mn;
  assign desc_data.hm1    = span[ROW_BITS-1:0];
  assign desc_data.status = !store ? ST_OVER : (tall ? ST_TALL : ST_OK);

  assign side_data = sp_r[side_idx] | sn_r[side_idx];

  always_comb begin
    if (last) cnt_nxt = '0;
    else if (store) cnt_nxt = cnt_r + 1'b1;
    else cnt_nxt = CNT_BITS'(MAX_POINTS + 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bank_r <= 1'b0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      if (last) bank_r <= !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      yprev_r <= py;
      ymin_r  <= mn;
      ymax_r  <= mx;
      if (first) y0_r <= py;
      sp_r[{bank_r, idx}] <= first ? 2'b00 : side_prev(py, yprev_r);
      if (!first) sn_r[{bank_r, prev_idx}] <= side_next(yprev_r, py);
      // wraparound neighbours of the last and the first vertex
      if (last) begin
        sn_r[{bank_r, idx}]           <= side_next(py, y0e);
        sp_r[{bank_r, {PT_BITS{1'b0}}}] <= side_prev(y0e, py);
      end
    end
  end

endmodule

@@ hw/rtl/cpss_desc_fifo.sv @@
// short queue of polygon descriptors between front and back
module cpss_desc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cpss_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output cpss_pkg::desc_t head
);
  import cpss_pkg::*;

  desc_t             ent_r [DQ_DEPTH];
  logic [DQ_PTR-1:0] wptr_r, rptr_r;
  logic [DQ_CNT-1:0] cnt_r;

  assign full  = cnt_r == DQ_CNT'(DQ_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_data;
  end

endmodule

@@ hw/rtl/cpss_back.sv @@
// back: marks rows, fills edge gaps by dda, emits one span per row, or a single status span for a rejected polygon
module cpss_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              desc_empty,
  input  cpss_pkg::desc_t                   desc_head,
  output logic                              desc_pop,
  output logic [cpss_pkg::VADDR_BITS-1:0]   vram_raddr,
  input  logic [2*cpss_pkg::COORD_BITS-1:0] vram_rdata,
  output logic [cpss_pkg::VADDR_BITS-1:0]   side_idx,
  input  logic [1:0]                        side_data,
  output logic                              out_empty,
  input  logic                              out_pop,
  output cpss_pkg::out_item_t               out_data
);
  import cpss_pkg::*;

  back_state_t                  state_r, state_nxt;
  desc_t                        desc_r;
  logic [PT_BITS-1:0]           i_r;
  logic signed [COORD_BITS-1:0] x_r;
  logic [ROW_BITS-1:0]          j_r;
  logic [1:0]                   sd_r;
  logic [1:0]                   flags_r [MAX_ROWS];
  logic                         any_r;
  logic [ROW_BITS-1:0]          start_r, end_r, r_r, anc_row_r, w_r, denom_r;
  logic                         pass_r;
  logic signed [COORD_BITS-1:0] anc_val_r, pv_r;
  logic                         neg_r, rev_r;
  logic signed [COORD_BITS+1:0] stp_r, dx_r;
  logic [ROW_BITS-1:0]          frac_r, acc_r;
  logic                         out_valid_r;
  out_item_t                    out_r;

  // row stores
  logic [ROW_BITS-1:0]   row_raddr;
  logic [COORD_BITS-1:0] left_rd, right_rd, wdata_l, wdata_r;
  logic                  we_l, we_r;
  logic [ROW_BITS-1:0]   row_waddr;
  logic signed [COORD_BITS-1:0] left_q, right_q;

  // divider
  logic                  div_start, div_done;
  logic [COORD_BITS-1:0] div_q;
  logic [ROW_BITS-1:0]   div_rem;

  // mark path
  logic signed [COORD_BITS-1:0] vx, vy, newl, newr;
  logic [COORD_BITS-1:0]        jdiff;
  logic [1:0]                   fl_j;

  // fill path
  logic                         fb, is_se, anchor, gap, at_end, adv, fill_end;
  logic signed [COORD_BITS-1:0] own_q, oth_q, v;
  logic signed [COORD_BITS:0]   diff;
  logic [COORD_BITS:0]          mag;
  logic signed [COORD_BITS+1:0] xs, x_n, stv;
  logic [ROW_BITS:0]            acc_sum;
  logic                         wrap;
  logic [ROW_BITS-1:0]          acc_n, w_n, gap_len;

  // emission path
  logic                         out_free, out_load, in_span;
  out_item_t                    item;

  cpss_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_ROWS)) u_left (
    .clk(clk), .we(we_l), .waddr(row_waddr), .wdata(wdata_l),
    .raddr(row_raddr), .rdata_r(left_rd)
  );

  cpss_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_ROWS)) u_right (
    .clk(clk), .we(we_r), .waddr(row_waddr), .wdata(wdata_r),
    .raddr(row_raddr), .rdata_r(right_rd)
  );

  cpss_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag[COORD_BITS-1:0]),
    .divisor(gap_len), .done(div_done), .quot(div_q), .rem(div_rem)
  );

  assign left_q  = left_rd;
  assign right_q = right_rd;

  assign vram_raddr = {desc_r.bank, i_r};
  assign side_idx   = {desc_r.bank, i_r};
  assign vx         = vram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign vy         = vram_rdata[COORD_BITS-1:0];
  assign jdiff      = vy - desc_r.ymin;
  assign row_raddr  = (state_r == B_MROW) ? jdiff[ROW_BITS-1:0] : r_r;

  assign fl_j = flags_r[j_r];
  assign newl = (fl_j[0] && left_q < x_r) ? left_q : x_r;
  assign newr = (fl_j[1] && right_q > x_r) ? right_q : x_r;

  assign own_q    = pass_r ? right_q : left_q;
  assign oth_q    = pass_r ? left_q : right_q;
  assign fb       = pass_r ? flags_r[r_r][1] : flags_r[r_r][0];
  assign is_se    = (r_r == start_r) || (r_r == end_r);
  assign anchor   = fb || is_se;
  // a one-edge start or end row copies its other edge
  assign v        = fb ? own_q : oth_q;
  assign gap_len  = r_r - anc_row_r;
  assign gap      = gap_len >= ROW_BITS'(2);
  assign diff     = {v[COORD_BITS-1], v} - {anc_val_r[COORD_BITS-1], anc_val_r};
  assign mag      = diff[COORD_BITS] ? -diff : diff;
  assign div_start = (state_r == B_FCHK) && anchor && gap;
  assign at_end   = r_r == end_r;

  assign xs       = dx_r + stp_r;
  assign acc_sum  = {1'b0, acc_r} + {1'b0, frac_r};
  assign wrap     = acc_sum >= {1'b0, denom_r};
  assign acc_n    = wrap ? ROW_BITS'(acc_sum - {1'b0, denom_r}) : acc_sum[ROW_BITS-1:0];
  assign x_n      = wrap ? (rev_r ? xs - 1'b1 : xs + 1'b1) : xs;
  assign w_n      = w_r + 1'b1;
  assign fill_end = w_n == r_r;

  always_comb begin
    if (pass_r) stv = (rev_r && acc_n != '0) ? x_n - 1'b1 : x_n;
    else stv = (acc_n == '0 || rev_r) ? x_n : x_n + 1'b1;
  end

  assign adv = ((state_r == B_FCHK) && !(anchor && gap)) || ((state_r == B_FILL) && fill_end);

  assign out_free = !out_valid_r || out_pop;
  assign in_span  = any_r && (r_r >= start_r) && (r_r <= end_r);

  always_comb begin
    item.row_y      = desc_r.ymin + COORD_BITS'(r_r);
    item.span_left  = '0;
    item.span_right = '1;
    item.last_row   = r_r == desc_r.hm1;
    item.status     = ST_OK;
    if (in_span) begin
      item.span_left  = (!flags_r[r_r][0] && is_se) ? right_q : left_q;
      item.span_right = (!flags_r[r_r][1] && is_se) ? left_q : right_q;
    end
    if (state_r == B_STAT) begin
      item.row_y    = '0;
      item.last_row = 1'b1;
      item.status   = desc_r.status;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!desc_empty) state_nxt = (desc_head.status != ST_OK) ? B_STAT : B_MRD;
      B_STAT: if (out_free) state_nxt = B_DONE;
      B_MRD:  state_nxt = B_MROW;
      B_MROW: state_nxt = B_MWR;
      B_MWR:  state_nxt = (i_r == desc_r.nlast) ? B_PREP : B_MRD;
      B_PREP: state_nxt = any_r ? B_FRD : B_ERD;
      B_FRD:  state_nxt = B_FCHK;
      B_FCHK: begin
        if (anchor && gap) state_nxt = B_DIV;
        else if (at_end && pass_r) state_nxt = B_ERD;
        else state_nxt = B_FRD;
      end
      B_DIV:  if (div_done) state_nxt = B_FILL;
      B_FILL: begin
        if (fill_end) state_nxt = (at_end && pass_r) ? B_ERD : B_FRD;
      end
      B_ERD:  state_nxt = B_EPUT;
      B_EPUT: if (out_free) state_nxt = item.last_row ? B_DONE : B_ERD;
      B_DONE: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    we_l      = 1'b0;
    we_r      = 1'b0;
    row_waddr = j_r;
    wdata_l   = newl;
    wdata_r   = newr;
    out_load  = 1'b0;
    desc_pop  = 1'b0;
    unique case (state_r)
      B_MWR: begin
        we_l = sd_r[0];
        we_r = sd_r[1];
      end
      B_FILL: begin
        row_waddr = w_r;
        wdata_l   = stv[COORD_BITS-1:0];
        wdata_r   = stv[COORD_BITS-1:0];
        we_l      = !pass_r;
        we_r      = pass_r;
      end
      B_STAT, B_EPUT: out_load = out_free;
      B_DONE: desc_pop = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      any_r       <= 1'b0;
      for (int k = 0; k < MAX_ROWS; k++) flags_r[k] <= 2'b00;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      if (state_r == B_IDLE) any_r <= 1'b0;
      if (state_r == B_MWR) begin
        flags_r[j_r] <= fl_j | sd_r;
        if (sd_r != 2'b00) any_r <= 1'b1;
      end
      if (state_r == B_DONE) begin
        for (int k = 0; k < MAX_ROWS; k++) flags_r[k] <= 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= item;
    unique case (state_r)
      B_IDLE: begin
        desc_r <= desc_head;
        i_r    <= '0;
      end
      B_MROW: begin
        x_r  <= vx;
        j_r  <= jdiff[ROW_BITS-1:0];
        sd_r <= side_data;
      end
      B_MWR: begin
        i_r <= i_r + 1'b1;
        if (sd_r != 2'b00) begin
          if (!any_r || j_r < start_r) start_r <= j_r;
          if (!any_r || j_r > end_r) end_r <= j_r;
        end
      end
      B_PREP: begin
        pass_r    <= 1'b0;
        r_r       <= any_r ? start_r : '0;
        anc_row_r <= start_r;
      end
      B_FCHK: begin
        if (anchor && gap) begin
          pv_r    <= v;
          denom_r <= gap_len;
          neg_r   <= diff[COORD_BITS];
          dx_r    <= {{2{anc_val_r[COORD_BITS-1]}}, anc_val_r};
        end else if (anchor) begin
          anc_row_r <= r_r;
          anc_val_r <= v;
        end
      end
      B_DIV: begin
        if (div_done) begin
          stp_r  <= neg_r ? -{2'b00, div_q} : {2'b00, div_q};
          frac_r <= div_rem;
          rev_r  <= neg_r && (div_rem != '0);
          acc_r  <= '0;
          w_r    <= anc_row_r + 1'b1;
        end
      end
      B_FILL: begin
        dx_r  <= x_n;
        acc_r <= acc_n;
        w_r   <= w_n;
        if (fill_end) begin
          anc_row_r <= r_r;
          anc_val_r <= pv_r;
        end
      end
      B_EPUT: if (out_free) r_r <= r_r + 1'b1;
      default: ;
    endcase
    // step to the next row, or to the next edge pass at the end row, or back to row 0 after the last pass
    if (adv) begin
      if (at_end) begin
        if (!pass_r) begin
          pass_r    <= 1'b1;
          r_r       <= start_r;
          anc_row_r <= start_r;
        end else begin
          r_r <= '0;
        end
      end else begin
        r_r <= r_r + 1'b1;
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/tb_convex_polygon_span_scan_core.sv @@
// tb for the convex polygon span scan core: random and corner-case polygons vs a span predictor
`timescale 1ns / 100ps

class span_scoreboard;
  localparam int NPT = cpss_pkg::MAX_POINTS;
  localparam int NROW = cpss_pkg::MAX_ROWS;

  longint vx[NPT];
  longint vy[NPT];
  int nvert;
  cpss_pkg::out_item_t pending_spans[$];
  int mismatches;

  function new();
    nvert = 0;
    mismatches = 0;
  endfunction

  function automatic cpss_pkg::out_item_t make_span(longint y, longint l, longint r, bit lst,
                                                    logic [1:0] st);
    cpss_pkg::out_item_t s;
    s.row_y = y[15:0];
    s.span_left = l[15:0];
    s.span_right = r[15:0];
    s.last_row = lst;
    s.status = st;
    return s;
  endfunction

  // interpolate one edge across rows that lack it
  function automatic void dda_fill(ref longint edge_x[NROW], ref logic [1:0] fl[NROW],
                                   input int first, input int h, input logic [1:0] bit_m,
                                   input bit is_right);
    int i1, i2, i;
    longint denom, x, d, stp, frac, acc;
    bit rev;
    i1 = first;
    while (i1 < h - 2) begin
      if ((fl[i1+1] & bit_m) != 0) begin
        i1++;
        continue;
      end
      i2 = i1 + 2;
      while (i2 < h && (fl[i2] & bit_m) == 0) i2++;
      if (i2 < h) begin
        denom = i2 - i1;
        x = edge_x[i1];
        d = edge_x[i2] - x;
        stp = d / denom;
        frac = d - stp * denom;
        rev = 0;
        acc = 0;
        if (frac < 0) begin
          frac = -frac;
          rev = 1;
        end
        for (i = i1 + 1; i < i2; i++) begin
          x += stp;
          acc += frac;
          if (acc >= denom) begin
            acc -= denom;
            x += rev ? -1 : 1;
          end
          if (is_right) edge_x[i] = (rev && acc != 0) ? x - 1 : x;
          else edge_x[i] = (acc == 0 || rev) ? x : x + 1;
        end
      end
      i1 = i2;
    end
  endfunction

  function automatic void note_vertex(cpss_pkg::in_item_t it);
    longint lx[NROW], rx[NROW];
    logic [1:0] fl[NROW];
    longint ymin, ymax, y, yp, yn;
    logic [1:0] sides;
    int n, h, j, first, lastr, r;
    if (nvert < NPT) begin
      vx[nvert] = longint'(it.point_x);
      vy[nvert] = longint'(it.point_y);
      nvert++;
    end else nvert = NPT + 1;
    if (!it.last_point) return;
    n = nvert;
    nvert = 0;
    if (n > NPT) begin
      pending_spans.push_back(make_span(0, 0, -1, 1, cpss_pkg::ST_OVER));
      return;
    end
    ymin = vy[0];
    ymax = vy[0];
    for (int i = 1; i < n; i++) begin
      if (vy[i] > ymax) ymax = vy[i];
      if (vy[i] < ymin) ymin = vy[i];
    end
    if (ymax - ymin + 1 > NROW) begin
      pending_spans.push_back(make_span(0, 0, -1, 1, cpss_pkg::ST_TALL));
      return;
    end
    h = int'(ymax - ymin + 1);
    for (int i = 0; i < NROW; i++) fl[i] = 2'b00;
    for (int i = 0; i < n; i++) begin
      y = vy[i];
      yp = vy[(i + n - 1) % n];
      yn = vy[(i + 1) % n];
      sides = 2'b00;
      if (y < yp) sides |= cpss_pkg::EDGE_R;
      else if (y > yp) sides |= cpss_pkg::EDGE_L;
      if (yn < y) sides |= cpss_pkg::EDGE_R;
      else if (yn > y) sides |= cpss_pkg::EDGE_L;
      j = int'(y - ymin);
      if ((sides & cpss_pkg::EDGE_R) != 0) begin
        if ((fl[j] & cpss_pkg::EDGE_R) == 0 || vx[i] > rx[j]) rx[j] = vx[i];
        fl[j] |= cpss_pkg::EDGE_R;
      end
      if ((sides & cpss_pkg::EDGE_L) != 0) begin
        if ((fl[j] & cpss_pkg::EDGE_L) == 0 || vx[i] < lx[j]) lx[j] = vx[i];
        fl[j] |= cpss_pkg::EDGE_L;
      end
    end
    first = 0;
    while (first < h && fl[first] == 0) first++;
    if (first == h) begin
      for (r = 0; r < h; r++)
        pending_spans.push_back(make_span(ymin + r, 0, -1, r == h - 1, cpss_pkg::ST_OK));
      return;
    end
    lastr = h - 1;
    while (fl[lastr] == 0) lastr--;
    for (r = 0; r < h; r++)
      if (r < first || r > lastr) begin
        lx[r] = 0;
        rx[r] = -1;
      end
    foreach (fl[k]) begin
      if ((k == first || k == lastr) && fl[k] != 2'b11) begin
        if (fl[k] == cpss_pkg::EDGE_R) lx[k] = rx[k];
        else rx[k] = lx[k];
        fl[k] = 2'b11;
      end
    end
    dda_fill(lx, fl, first, h, cpss_pkg::EDGE_L, 0);
    dda_fill(rx, fl, first, h, cpss_pkg::EDGE_R, 1);
    for (r = 0; r < h; r++)
      pending_spans.push_back(make_span(ymin + r, lx[r], rx[r], r == h - 1, cpss_pkg::ST_OK));
  endfunction

  function automatic void check_span(cpss_pkg::out_item_t got);
    cpss_pkg::out_item_t exp_s;
    if (pending_spans.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected span: %p", got);
      return;
    end
    exp_s = pending_spans.pop_front();
    if (got !== exp_s) begin
      mismatches++;
      if (mismatches <= 10) $display("span mismatch: expected %p, got %p", exp_s, got);
    end
  endfunction
endclass

module tb_convex_polygon_span_scan_core;
  import cpss_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 0;
  out_item_t out_data;

  span_scoreboard sb = new();
  int cycle_count = 0;
  int items_sent = 0;
  bit stim_done = 0;
  int burst_left = 0;
  int gap_left = 0;
  in_item_t vert_q[$];

  convex_polygon_span_scan_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver stall pattern: long open stretches, then bursty stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && !out_empty && out_pop) sb.check_span(out_data);
    if ((cycle_count / 400) % 3 == 0) out_pop <= 1'b1;
    else out_pop <= ($urandom_range(0, 3) != 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** convex_polygon_span_scan_core: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t vtx(int x, int y, bit lst);
    in_item_t v;
    v.point_x = x[15:0];
    v.point_y = y[15:0];
    v.last_point = lst;
    return v;
  endfunction

  // random convex polygon: points on an ellipse-like loop in angular order
  task automatic add_polygon(int n, int h);
    int cx, cy, w, ang;
    real a;
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    if (cy > 32700) cy = 32700;
    if (cy < -32700) cy = -32700;
    w = $urandom_range(0, 200);
    ang = $urandom_range(0, 359);
    for (int i = 0; i < n; i++) begin
      a = 6.2831853 * (ang + i * 360.0 / n) / 360.0;
      vert_q.push_back(vtx(cx + $rtoi(w * $cos(a)), cy + $rtoi(h / 2.0 * $sin(a)),
                           i == n - 1));
    end
  endtask

  task automatic send_item(in_item_t it);
    while (gap_left > 0) begin
      gap_left--;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_vertex(it);
    items_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
    if (gap_left > 0) in_push <= 1'b0;
  endtask

  task automatic drain_queue();
    while (vert_q.size() > 0) send_item(vert_q.pop_front());
    // push may still be up for a back-to-back transfer
    if (gap_left == 0) begin
      in_push <= 1'b0;
      gap_left = 1;
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, degenerate shapes and error cases
    vert_q.push_back(vtx(-32768, 32767, 1));
    vert_q.push_back(vtx(32767, -32768, 0));
    vert_q.push_back(vtx(-32768, -32768, 1));
    vert_q.push_back(vtx(0, 0, 0));
    vert_q.push_back(vtx(10, 0, 0));
    vert_q.push_back(vtx(5, 0, 1));
    vert_q.push_back(vtx(0, 0, 0));
    vert_q.push_back(vtx(100, 63, 0));
    vert_q.push_back(vtx(-100, 30, 1));
    vert_q.push_back(vtx(-5, 100, 0));
    vert_q.push_back(vtx(5, 164, 1));
    for (int i = 0; i < 17; i++) vert_q.push_back(vtx(i, i, i == 16));
    drain_queue();
    // hold off until all spans are out
    while (sb.pending_spans.size() > 0) @(posedge clk);
    while (items_sent < 180 || sb.pending_spans.size() > 0 && vert_q.size() > 0) begin
      case ($urandom_range(0, 9))
        0: for (int i = 0; i < $urandom_range(1, 4); i++)
             vert_q.push_back(vtx($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 1)));
        1: add_polygon($urandom_range(3, 18), $urandom_range(0, 90));
        default: add_polygon($urandom_range(1, 16), $urandom_range(0, 63));
      endcase
      if (vert_q[vert_q.size()-1].last_point == 0)
        vert_q[vert_q.size()-1].last_point = 1;
      drain_queue();
    end
    stim_done = 1;
    wait_cycles = 0;
    while (sb.pending_spans.size() > 0 && wait_cycles < 200000) begin
      wait_cycles++;
      @(posedge clk);
    end
    repeat (500) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_spans.size() == 0)
      $display("** convex_polygon_span_scan_core: PASSED **");
    else
      $display("** convex_polygon_span_scan_core: FAILED **");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/cpss_pkg.sv
hw/rtl/cpss_ram.sv
hw/rtl/cpss_div.sv
hw/rtl/cpss_front.sv
hw/rtl/cpss_desc_fifo.sv
hw/rtl/cpss_back.sv
hw/rtl/convex_polygon_span_scan_core.sv
tb/tb_convex_polygon_span_scan_core.sv
